// File: rtl/kwl_pkg.sv
// Shared constants, types and keyword tables of the keyword lexer.
package kwl_pkg;

  localparam int MAX_LEN     = 64;
  localparam int OFFSET_BITS = 16;
  localparam int LINE_BITS   = 16;

  localparam int RUN_W   = $clog2(MAX_LEN);
  localparam int CUT_LEN = MAX_LEN - 1;

  localparam int KIND_W = 5;
  localparam int OUT_W  = 16;
  localparam int LEN_W  = 6;

  localparam int FIFO_DEPTH = 4;

  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_INT     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PUNCT0  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd29;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int NKW = 16;
  // Keyword text, right-justified: first character in the highest used byte.
  localparam logic [63:0] KW_STR [NKW] = '{
    "use", "fun", "if", "else", "break", "continue", "while", "for",
    "switch", "true", "false", "int", "double", "char", "string", "boolean"
  };
  localparam int unsigned KW_LEN [NKW] = '{3, 3, 2, 4, 5, 8, 5, 3, 6, 4, 5, 3, 6, 4, 6, 7};

  localparam int NPUNCT = 10;
  localparam logic [7:0] PUNCT [NPUNCT] = '{"(", ")", "{", "}", "[", "]", ",", ":", ";", "?"};

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [RUN_W-1:0]       runlen_t;
  typedef logic [NKW-1:0]         cand_t;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_SLASH   = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [OUT_W-1:0]  start_offset;
    logic [LEN_W-1:0]  token_length;
    logic [OUT_W-1:0]  start_line;
    logic              last_of_run;
  } token_t;

  // Tokens handed from the scanner to the output queue in one cycle.
  typedef struct packed {
    logic [1:0]        count;
    token_t [1:0]      tok;
  } push_t;

endpackage

// File: rtl/kwl_if.sv
// Channel interfaces of the keyword lexer: text bytes in, tokens out.
interface kwl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface kwl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [5:0]  token_length;
  logic [15:0] start_line;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output start_line, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input start_line, input last_of_run,
                  output ready);
endinterface

// File: rtl/kwl_scan.sv
// Input register, scanner state and the single-pass tokenizing step.
module kwl_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_code,
  input  logic             end_of_text,
  input  logic             room,
  output kwl_pkg::push_t   push
);

  logic                    hold_valid;
  logic [7:0]              hold_char;
  logic                    hold_eot;
  logic                    fire;

  kwl_pkg::mode_t          mode, mode_next;
  kwl_pkg::offset_t        run_start, run_start_next;
  kwl_pkg::runlen_t        run_length, run_length_next;
  kwl_pkg::cand_t          cand, cand_next;
  kwl_pkg::offset_t        byte_offset, byte_offset_next;
  kwl_pkg::line_t          line_count, line_count_next;
  kwl_pkg::line_t          run_line, run_line_next;
  logic                    finished, finished_next;

  logic [1:0]              n;
  kwl_pkg::token_t [1:0]   toks;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic kwl_pkg::token_t mk_tok(input logic [4:0] kind, input logic [31:0] off,
                                            input logic [31:0] len, input logic [31:0] line);
    kwl_pkg::token_t t;
    t.token_kind   = kind;
    t.start_offset = sat16(off);
    t.token_length = (len > 32'd63) ? 6'd63 : len[5:0];
    t.start_line   = sat16(line);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // Drop every keyword whose character at position pos is not c.
  function automatic kwl_pkg::cand_t filter(input kwl_pkg::cand_t cin,
                                            input logic [31:0] pos, input logic [7:0] c);
    kwl_pkg::cand_t r;
    logic [2:0]     p;
    r = cin;
    for (int k = 0; k < kwl_pkg::NKW; k++) begin
      p = 3'(kwl_pkg::KW_LEN[k] - 1 - pos);
      if (!(pos < kwl_pkg::KW_LEN[k] && kwl_pkg::KW_STR[k][{p, 3'b000} +: 8] == c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] word_kind(input kwl_pkg::cand_t cin, input logic [31:0] len);
    logic [4:0] kind;
    kind = kwl_pkg::KIND_IDENT;
    for (int k = 0; k < kwl_pkg::NKW; k++) begin
      if (cin[k] && kwl_pkg::KW_LEN[k] == len) begin
        kind = 5'(kwl_pkg::KIND_KW0 + k);
      end
    end
    return kind;
  endfunction

  // Character classes
  logic        is_alpha, is_digit, is_space, is_punct, is_word;
  logic [4:0]  punct_kind;

  always_comb begin
    is_alpha = (hold_char >= "a" && hold_char <= "z") || (hold_char >= "A" && hold_char <= "Z");
    is_digit = hold_char >= "0" && hold_char <= "9";
    is_space = hold_char == kwl_pkg::CH_SPACE || hold_char == kwl_pkg::CH_NL ||
               hold_char == kwl_pkg::CH_TAB || hold_char == kwl_pkg::CH_CR;
    is_word  = is_alpha || is_digit || hold_char == kwl_pkg::CH_UNDER;
    is_punct   = 1'b0;
    punct_kind = kwl_pkg::KIND_UNKNOWN;
    for (int k = 0; k < kwl_pkg::NPUNCT; k++) begin
      if (hold_char == kwl_pkg::PUNCT[k]) begin
        is_punct   = 1'b1;
        punct_kind = 5'(kwl_pkg::KIND_PUNCT0 + k);
      end
    end
  end

  // Run paths: flush as is, grow by this byte, or start a new one.
  kwl_pkg::cand_t   cand_grow, cand_new;
  kwl_pkg::runlen_t len_grow;
  logic             grow_cut, new_cut;
  kwl_pkg::token_t  flush_tok, grown_tok, new_tok;
  logic [4:0]       flush_kind, grown_kind, new_kind;

  always_comb begin
    cand_grow  = filter(cand, 32'(run_length), hold_char);
    len_grow   = run_length + 1'b1;
    grow_cut   = 32'(len_grow) >= kwl_pkg::CUT_LEN;
    cand_new   = filter('1, 32'd0, hold_char);
    new_cut    = 1 >= kwl_pkg::CUT_LEN;
    flush_kind = (mode == kwl_pkg::MODE_IDENT) ? word_kind(cand, 32'(run_length))
                                                : kwl_pkg::KIND_INT;
    grown_kind = (mode == kwl_pkg::MODE_IDENT) ? word_kind(cand_grow, 32'(len_grow))
                                                : kwl_pkg::KIND_INT;
    new_kind   = is_alpha ? word_kind(cand_new, 32'd1) : kwl_pkg::KIND_INT;
    flush_tok  = mk_tok(flush_kind, 32'(run_start), 32'(run_length), 32'(run_line));
    grown_tok  = mk_tok(grown_kind, 32'(run_start), 32'(len_grow), 32'(run_line));
    new_tok    = mk_tok(new_kind, 32'(byte_offset), 32'd1, 32'(line_count));
  end

  // Next state and emitted tokens
  logic do_start;

  always_comb begin
    mode_next        = mode;
    run_start_next   = run_start;
    run_length_next  = run_length;
    cand_next        = cand;
    byte_offset_next = byte_offset;
    line_count_next  = line_count;
    run_line_next    = run_line;
    finished_next    = finished;
    n                = 2'd0;
    toks             = '0;
    do_start         = 1'b0;

    if (finished) begin
      toks[0] = mk_tok(kwl_pkg::KIND_EOF, 32'(byte_offset), 32'd0, 32'(line_count));
      n       = 2'd1;
    end else if (hold_eot) begin
      if (mode == kwl_pkg::MODE_IDENT || mode == kwl_pkg::MODE_NUMBER) begin
        toks[0] = flush_tok;
        n       = 2'd1;
      end else if (mode == kwl_pkg::MODE_SLASH) begin
        toks[0] = mk_tok(kwl_pkg::KIND_UNKNOWN, 32'(run_start), 32'd1, 32'(run_line));
        n       = 2'd1;
      end
      toks[n[0]] = mk_tok(kwl_pkg::KIND_EOF, 32'(byte_offset), 32'd0, 32'(line_count));
      n          = n + 2'd1;
      mode_next     = kwl_pkg::MODE_IDLE;
      finished_next = 1'b1;
    end else begin
      unique case (mode)
        kwl_pkg::MODE_IDENT, kwl_pkg::MODE_NUMBER: begin
          if ((mode == kwl_pkg::MODE_IDENT) ? is_word : is_digit) begin
            if (mode == kwl_pkg::MODE_IDENT) cand_next = cand_grow;
            run_length_next = len_grow;
            if (grow_cut) begin
              toks[0]   = grown_tok;
              n         = 2'd1;
              mode_next = kwl_pkg::MODE_IDLE;
            end
          end else begin
            toks[0]   = flush_tok;
            n         = 2'd1;
            mode_next = kwl_pkg::MODE_IDLE;
            do_start  = 1'b1;
          end
        end
        kwl_pkg::MODE_SLASH: begin
          if (hold_char == kwl_pkg::CH_SLASH) begin
            mode_next = kwl_pkg::MODE_COMMENT;
          end else begin
            toks[0]   = mk_tok(kwl_pkg::KIND_UNKNOWN, 32'(run_start), 32'd1, 32'(run_line));
            n         = 2'd1;
            mode_next = kwl_pkg::MODE_IDLE;
            do_start  = 1'b1;
          end
        end
        kwl_pkg::MODE_COMMENT: begin
          if (hold_char == kwl_pkg::CH_NL) mode_next = kwl_pkg::MODE_IDLE;
        end
        default: begin
          mode_next = kwl_pkg::MODE_IDLE;
          do_start  = 1'b1;
        end
      endcase

      if (do_start && !is_space) begin
        if (is_alpha || is_digit) begin
          mode_next       = is_alpha ? kwl_pkg::MODE_IDENT : kwl_pkg::MODE_NUMBER;
          run_start_next  = byte_offset;
          run_line_next   = line_count;
          run_length_next = kwl_pkg::runlen_t'(1);
          cand_next       = cand_new;
          if (new_cut) begin
            toks[n[0]] = new_tok;
            n          = n + 2'd1;
            mode_next  = kwl_pkg::MODE_IDLE;
          end
        end else if (hold_char == kwl_pkg::CH_SLASH) begin
          mode_next      = kwl_pkg::MODE_SLASH;
          run_start_next = byte_offset;
          run_line_next  = line_count;
        end else begin
          toks[n[0]] = mk_tok(is_punct ? punct_kind : kwl_pkg::KIND_UNKNOWN,
                              32'(byte_offset), 32'd1, 32'(line_count));
          n          = n + 2'd1;
        end
      end

      if (byte_offset != '1) byte_offset_next = byte_offset + 1'b1;
      if (hold_char == kwl_pkg::CH_NL && line_count != '1) line_count_next = line_count + 1'b1;
    end

    if (n == 2'd1) toks[0].last_of_run = 1'b1;
    if (n == 2'd2) toks[1].last_of_run = 1'b1;
  end

  assign fire       = hold_valid && room;
  assign in_ready   = !hold_valid || fire;
  assign push.count = fire ? n : 2'd0;
  assign push.tok   = toks;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_char <= char_code;
      hold_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= kwl_pkg::MODE_IDLE;
      run_start   <= '0;
      run_length  <= '0;
      cand        <= '1;
      byte_offset <= '0;
      line_count  <= kwl_pkg::line_t'(1);
      run_line    <= kwl_pkg::line_t'(1);
      finished    <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      run_start   <= run_start_next;
      run_length  <= run_length_next;
      cand        <= cand_next;
      byte_offset <= byte_offset_next;
      line_count  <= line_count_next;
      run_line    <= run_line_next;
      finished    <= finished_next;
    end
  end

  // Whenever tokens are pushed, only the last one of the item is marked.
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.tok[1].last_of_run && !push.tok[0].last_of_run)
    else $error("two-token push with wrong last_of_run marks");

  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd1 |-> push.tok[0].last_of_run)
    else $error("single-token push not marked last");

  a_no_three: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("scanner pushed more than two tokens");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("end-of-text state cleared");

  a_eof_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && finished |-> push.count == 2'd1 && push.tok[0].token_kind == kwl_pkg::KIND_EOF)
    else $error("item after end of text did not give a single EOF");

endmodule

// File: rtl/kwl_tok_fifo.sv
// Small token queue: up to two writes per cycle, one registered read port.
module kwl_tok_fifo (
  input  logic             clk,
  input  logic             rst,
  input  kwl_pkg::push_t   push,
  output logic             room,
  output logic             head_valid,
  output kwl_pkg::token_t  head,
  input  logic             pop_ready
);

  localparam int PTR_W = $clog2(kwl_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(kwl_pkg::FIFO_DEPTH + 1);

  kwl_pkg::token_t   mem [kwl_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && pop_ready;
  assign room       = 32'(count) <= kwl_pkg::FIFO_DEPTH - 2;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.tok[0];
    if (push.count == 2'd2) mem[wr_ptr + 1'b1] <= push.tok[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/keyword_lexer.sv
// Top level of the keyword lexer: streaming byte-to-token scanner.
//
// keyword_lexer takes source text one byte per item on text_in and emits
// tokens on tokens as kind, start offset, length and start line. Spaces,
// tabs, CR and LF are skipped, "//" comments run to the next LF, and each
// LF bumps the line count. Letter-led runs resolve to one of 16 keywords or
// an identifier; digit runs are integers; ( ) { } [ ] , : ; ? are tokens of
// their own; anything else, including a lone '/', is an unknown token of
// length 1. A run is cut at MAX_LEN-1 bytes. An item with end_of_text set
// flushes any pending run and gives EOF; every item after that gives EOF
// again. One input item is taken per cycle while the output queue has
// room. Each item is registered, then scanned in one pass that writes zero,
// one or two tokens into a four-entry output queue whose head drives tokens
// directly. The token channel moves one item per cycle while tokens.ready
// is high, so a stream where items cause two tokens is paced by the output
// side: text_in.ready drops while a byte is held and the queue holds more
// than two tokens. Offsets and lines saturate at 65535.
module keyword_lexer (
  input  logic      clk,
  input  logic      rst,
  kwl_in_if.sink    text_in,
  kwl_out_if.source tokens
);

  kwl_pkg::push_t   push;
  kwl_pkg::token_t  head;
  logic             room;
  logic             head_valid;

  // Input register plus tokenizing step
  kwl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (text_in.valid),
    .in_ready    (text_in.ready),
    .char_code   (text_in.char_code),
    .end_of_text (text_in.end_of_text),
    .room        (room),
    .push        (push)
  );

  // Result queue; its head is the output register
  kwl_tok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop_ready  (tokens.ready)
  );

  assign tokens.valid        = head_valid;
  assign tokens.token_kind   = head.token_kind;
  assign tokens.start_offset = head.start_offset;
  assign tokens.token_length = head.token_length;
  assign tokens.start_line   = head.start_line;
  assign tokens.last_of_run  = head.last_of_run;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for keyword_lexer: scripted and random source text, token checks.
`timescale 1ns / 1ps

module tb_top;

  // Prediction of the token stream plus the queue of tokens still owed by the lexer.
  class token_scoreboard;
    kwl_pkg::token_t  due[$];
    int               errors;

    // lexer state as the scanner should hold it
    kwl_pkg::mode_t           scan_mode;
    int                       run_start;
    int                       run_len;
    int                       run_line;
    logic [kwl_pkg::NKW-1:0]  cands;
    int                       byte_offset;
    int                       line_count;
    bit                       finished;

    // last token of the current byte is held back so last_of_run can be set on it
    kwl_pkg::token_t  held;
    bit               have_held;

    function new();
      due.delete();
      errors      = 0;
      scan_mode   = kwl_pkg::MODE_IDLE;
      run_start   = 0;
      run_len     = 0;
      run_line    = 1;
      cands       = '1;
      byte_offset = 0;
      line_count  = 1;
      finished    = 0;
      have_held   = 0;
    endfunction

    static function string kw_word(int k);
      case (k)
        0:  return "use";
        1:  return "fun";
        2:  return "if";
        3:  return "else";
        4:  return "break";
        5:  return "continue";
        6:  return "while";
        7:  return "for";
        8:  return "switch";
        9:  return "true";
        10: return "false";
        11: return "int";
        12: return "double";
        13: return "char";
        14: return "string";
        default: return "boolean";
      endcase
    endfunction

    static function int punct_index(logic [7:0] c);
      case (c)
        "(": return 0;
        ")": return 1;
        "{": return 2;
        "}": return 3;
        "[": return 4;
        "]": return 5;
        ",": return 6;
        ":": return 7;
        ";": return 8;
        "?": return 9;
        default: return -1;
      endcase
    endfunction

    static function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    static function bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == kwl_pkg::CH_SPACE || c == kwl_pkg::CH_NL || c == kwl_pkg::CH_TAB ||
             c == kwl_pkg::CH_CR;
    endfunction

    function void emit(logic [kwl_pkg::KIND_W-1:0] kind, int off, int len, int line);
      kwl_pkg::token_t t;
      if (have_held) due.push_back(held);
      t.token_kind   = kind;
      t.start_offset = (off > 65535) ? 16'hFFFF : off[15:0];
      t.token_length = (len > 63) ? 6'd63 : len[5:0];
      t.start_line   = (line > 65535) ? 16'hFFFF : line[15:0];
      t.last_of_run  = 1'b0;
      held      = t;
      have_held = 1;
    endfunction

    function void flush_run();
      logic [kwl_pkg::KIND_W-1:0] kind;
      string                      w;
      kind = kwl_pkg::KIND_INT;
      if (scan_mode == kwl_pkg::MODE_IDENT) begin
        kind = kwl_pkg::KIND_IDENT;
        for (int k = 0; k < kwl_pkg::NKW; k++) begin
          w = kw_word(k);
          if (cands[k] && w.len() == run_len) kind = 5'(kwl_pkg::KIND_KW0 + k);
        end
      end
      emit(kind, run_start, run_len, run_line);
      scan_mode = kwl_pkg::MODE_IDLE;
    endfunction

    function void grow_run(logic [7:0] c);
      string w;
      if (scan_mode == kwl_pkg::MODE_IDENT) begin
        for (int k = 0; k < kwl_pkg::NKW; k++) begin
          w = kw_word(k);
          if (!(run_len < w.len() && w[run_len] == c)) cands[k] = 1'b0;
        end
      end
      run_len++;
      if (run_len >= kwl_pkg::MAX_LEN - 1) flush_run();
    endfunction

    function void begin_token(logic [7:0] c, int off);
      int p;
      if (is_blank(c)) return;
      if (is_letter(c) || is_num(c)) begin
        scan_mode = is_letter(c) ? kwl_pkg::MODE_IDENT : kwl_pkg::MODE_NUMBER;
        run_start = off;
        run_line  = line_count;
        run_len   = 0;
        cands     = '1;
        grow_run(c);
        return;
      end
      if (c == kwl_pkg::CH_SLASH) begin
        scan_mode = kwl_pkg::MODE_SLASH;
        run_start = off;
        run_line  = line_count;
        return;
      end
      p = punct_index(c);
      if (p >= 0) emit(5'(kwl_pkg::KIND_PUNCT0 + p), off, 1, line_count);
      else emit(kwl_pkg::KIND_UNKNOWN, off, 1, line_count);
    endfunction

    // One accepted byte (or end mark): queue the tokens it must produce.
    function void note_byte(logic [7:0] c, logic eot);
      int off;
      if (finished) begin
        emit(kwl_pkg::KIND_EOF, byte_offset, 0, line_count);
      end else if (eot) begin
        if (scan_mode == kwl_pkg::MODE_IDENT || scan_mode == kwl_pkg::MODE_NUMBER) flush_run();
        else if (scan_mode == kwl_pkg::MODE_SLASH)
          emit(kwl_pkg::KIND_UNKNOWN, run_start, 1, run_line);
        scan_mode = kwl_pkg::MODE_IDLE;
        emit(kwl_pkg::KIND_EOF, byte_offset, 0, line_count);
        finished = 1;
      end else begin
        off = byte_offset;
        case (scan_mode)
          kwl_pkg::MODE_IDENT: begin
            if (is_letter(c) || is_num(c) || c == kwl_pkg::CH_UNDER) grow_run(c);
            else begin
              flush_run();
              begin_token(c, off);
            end
          end
          kwl_pkg::MODE_NUMBER: begin
            if (is_num(c)) grow_run(c);
            else begin
              flush_run();
              begin_token(c, off);
            end
          end
          kwl_pkg::MODE_SLASH: begin
            if (c == kwl_pkg::CH_SLASH) scan_mode = kwl_pkg::MODE_COMMENT;
            else begin
              emit(kwl_pkg::KIND_UNKNOWN, run_start, 1, run_line);
              scan_mode = kwl_pkg::MODE_IDLE;
              begin_token(c, off);
            end
          end
          kwl_pkg::MODE_COMMENT: begin
            if (c == kwl_pkg::CH_NL) scan_mode = kwl_pkg::MODE_IDLE;
          end
          default: begin
            scan_mode = kwl_pkg::MODE_IDLE;
            begin_token(c, off);
          end
        endcase
        if (byte_offset < 2 ** kwl_pkg::OFFSET_BITS - 1) byte_offset++;
        if (c == kwl_pkg::CH_NL && line_count < 2 ** kwl_pkg::LINE_BITS - 1) line_count++;
      end
      if (have_held) begin
        held.last_of_run = 1'b1;
        due.push_back(held);
        have_held = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_token(kwl_pkg::token_t got);
      kwl_pkg::token_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected token kind=%0d off=%0d len=%0d line=%0d",
                         got.token_kind, got.start_offset, got.token_length,
                         got.start_line));
        return;
      end
      want = due.pop_front();
      if (got !== want)
        report($sformatf("got kind=%0d off=%0d len=%0d line=%0d last=%0b, want %0d %0d %0d %0d %0b",
                         got.token_kind, got.start_offset, got.token_length,
                         got.start_line, got.last_of_run, want.token_kind,
                         want.start_offset, want.token_length, want.start_line,
                         want.last_of_run));
    endtask
  endclass

  logic clk;
  logic rst;

  kwl_in_if  text_in_if ();
  kwl_out_if tokens_if ();

  keyword_lexer u_top (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in_if),
    .tokens  (tokens_if)
  );

  token_scoreboard lexer_sb;

  // bytes waiting to be sent, built a piece of source text at a time
  logic [7:0] text_q[$];

  // idle odds in percent for the byte sender and the token receiver
  int send_idle_pct;
  int recv_stall_pct;

  kwl_pkg::token_t got_tok;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[keyword_lexer] ERROR");
    $finish;
  end

  // Token receiver: ready changes on the falling edge only.
  initial begin
    tokens_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tokens_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted token goes straight to the checker.
  always @(posedge clk) begin
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      got_tok.token_kind   = tokens_if.token_kind;
      got_tok.start_offset = tokens_if.start_offset;
      got_tok.token_length = tokens_if.token_length;
      got_tok.start_line   = tokens_if.start_line;
      got_tok.last_of_run  = tokens_if.last_of_run;
      lexer_sb.check_token(got_tok);
    end
  end

  // Offer one byte; returns on the falling edge after it was taken.
  task automatic send_item(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in_if.valid = 1'b0;
      @(negedge clk);
    end
    text_in_if.valid       = 1'b1;
    text_in_if.char_code   = c;
    text_in_if.end_of_text = eot;
    do @(posedge clk); while (!text_in_if.ready);
    lexer_sb.note_byte(c, eot);
    @(negedge clk);
  endtask

  task automatic send_pending();
    while (text_q.size() != 0) send_item(text_q.pop_front(), 1'b0);
  endtask

  // Sender holds off until the lexer has delivered every token owed.
  task automatic wait_drained();
    text_in_if.valid = 1'b0;
    while (lexer_sb.due.size() != 0) @(negedge clk);
  endtask

  task automatic push_word(input string w);
    for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a") + 8'($urandom_range(25));
    if ($urandom_range(3) == 0) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(5))
      0:       return rand_digit();
      1:       return kwl_pkg::CH_UNDER;
      default: return rand_letter();
    endcase
  endfunction

  // One chunk of plausible source text, now and then plain noise.
  task automatic add_random_piece();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 22) begin
      push_word(token_scoreboard::kw_word($urandom_range(kwl_pkg::NKW - 1)));
    end else if (pick < 40) begin
      // identifier, sometimes a keyword with a tail
      if ($urandom_range(2) == 0)
        push_word(token_scoreboard::kw_word($urandom_range(kwl_pkg::NKW - 1)));
      else text_q.push_back(rand_letter());
      n = $urandom_range(0, 8);
      repeat (n) text_q.push_back(rand_word_char());
    end else if (pick < 52) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(rand_digit());
    end else if (pick < 66) begin
      case ($urandom_range(9))
        0: push_word("(");
        1: push_word(")");
        2: push_word("{");
        3: push_word("}");
        4: push_word("[");
        5: push_word("]");
        6: push_word(",");
        7: push_word(":");
        8: push_word(";");
        default: push_word("?");
      endcase
    end else if (pick < 74) begin
      // comment with arbitrary bytes up to the newline
      push_word("//");
      n = $urandom_range(0, 10);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == kwl_pkg::CH_NL) c = kwl_pkg::CH_SPACE;
        text_q.push_back(c);
      end
      text_q.push_back(kwl_pkg::CH_NL);
    end else if (pick < 80) begin
      text_q.push_back(kwl_pkg::CH_SLASH);
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0:       text_q.push_back(kwl_pkg::CH_NL);
        1:       text_q.push_back(kwl_pkg::CH_CR);
        default: text_q.push_back(kwl_pkg::CH_TAB);
      endcase
    end else if (pick < 96) begin
      text_q.push_back(8'($urandom_range(255)));
    end else if (pick < 98) begin
      // run that is mostly long enough to be cut, maybe twice
      text_q.push_back(rand_letter());
      n = $urandom_range(60, 130);
      repeat (n) text_q.push_back(rand_word_char());
    end else begin
      n = $urandom_range(60, 130);
      repeat (n) text_q.push_back(rand_digit());
    end
    if ($urandom_range(9) < 7) text_q.push_back(kwl_pkg::CH_SPACE);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      add_random_piece();
      sent += text_q.size();
      send_pending();
    end
  endtask

  initial begin
    rst                    = 1'b1;
    text_in_if.valid       = 1'b0;
    text_in_if.char_code   = 8'h00;
    text_in_if.end_of_text = 1'b0;
    send_idle_pct          = 8;
    recv_stall_pct         = 77;
    lexer_sb               = new();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opener: keyword next to punctuation, identifier with '_',
    // integer, lone slash, a comment, extreme and control bytes, blanks.
    push_word("if(x_9)");
    push_word("42;");
    push_word("/a");
    push_word("//z\n");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h7F);
    text_q.push_back(kwl_pkg::CH_TAB);
    text_q.push_back(kwl_pkg::CH_CR);
    push_word("[,:]");
    send_pending();

    // Phase 1: sender mostly busy, receiver stalls a lot.
    run_random(400);
    wait_drained();

    // Phase 2: the other way round.
    send_idle_pct  = 77;
    recv_stall_pct = 8;
    run_random(400);

    // Phase 3: full rate both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(300);

    // Mixed stalls on both sides.
    send_idle_pct  = 8;
    recv_stall_pct = 40;
    run_random(100);

    // End of text lands in one of the scanner's states, picked at random.
    case ($urandom_range(4))
      0:       push_word(" ");
      1:       push_word("else");
      2:       push_word("123");
      3:       push_word("/");
      default: push_word("// tail");
    endcase
    send_pending();
    send_item(8'($urandom_range(255)), 1'b1);

    // After the end mark every byte just repeats EOF.
    repeat (4) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));

    wait_drained();
    repeat (20) @(posedge clk);
    if (lexer_sb.errors == 0) begin
      $display("[keyword_lexer] OK");
    end else begin
      $display("[keyword_lexer] ERROR");
    end
    $finish;
  end

endmodule
